// ===== rtl/hsv_pkg.sv =====
// shared types and constants for the hsv to rgb converter
// no dependencies
`default_nettype none

package hsv_pkg;

    localparam int HUE_W     = 16;
    localparam int UNIT_W    = 10;
    localparam int WRAP_W    = 15;
    localparam int REM_W     = 12;
    localparam int OUT_W     = 8;
    localparam int HUE_TURN   = 23040;
    localparam int HUE_SECTOR = 3840;

    // 60-degree hue sectors
    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } sector_t;

    typedef struct packed {
        sector_t           sector;
        logic [REM_W-1:0]  rem;
        logic [UNIT_W-1:0] sat;
        logic [UNIT_W-1:0] val;
        logic [UNIT_W-1:0] alp;
        logic              gray;
    } hsv_sect_t;

endpackage

`default_nettype wire

// ===== rtl/hsv_if.sv =====
// valid/ready stream interfaces for hsv items in and rgb items out
// depends on hsv_pkg for field widths
`default_nettype none

interface hsv_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [hsv_pkg::HUE_W-1:0]     hue_angle;
    logic signed [hsv_pkg::UNIT_W-1:0]    saturation;
    logic signed [hsv_pkg::UNIT_W-1:0]    brightness;
    logic signed [hsv_pkg::UNIT_W-1:0]    alpha_in;

    modport source (output valid, hue_angle, saturation, brightness, alpha_in, input ready);
    modport sink   (input valid, hue_angle, saturation, brightness, alpha_in, output ready);
endinterface

interface hsv_out_if;
    logic                          valid;
    logic                          ready;
    logic [hsv_pkg::OUT_W-1:0]     red;
    logic [hsv_pkg::OUT_W-1:0]     green;
    logic [hsv_pkg::OUT_W-1:0]     blue;
    logic [hsv_pkg::OUT_W-1:0]     alpha_out;

    modport source (output valid, red, green, blue, alpha_out, input ready);
    modport sink   (input valid, red, green, blue, alpha_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/hsv_sector.sv =====
// front end: clamps s/v/alpha, wraps the hue and splits it into sector and remainder
// two register stages; depends on hsv_pkg
`default_nettype none

module hsv_sector #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [hsv_pkg::HUE_W-1:0]      hue_angle,
    input  wire logic signed [hsv_pkg::UNIT_W-1:0]     saturation,
    input  wire logic signed [hsv_pkg::UNIT_W-1:0]     brightness,
    input  wire logic signed [hsv_pkg::UNIT_W-1:0]     alpha_in,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output hsv_pkg::hsv_sect_t                         out_data
);

    localparam int ONE_I = 1 << FRAC_BITS;
    localparam int CMP_W = (FRAC_BITS + 2 > hsv_pkg::UNIT_W) ? FRAC_BITS + 2 : hsv_pkg::UNIT_W;
    localparam logic [hsv_pkg::UNIT_W-1:0] ONE_CLAMP =
        (ONE_I > 511) ? hsv_pkg::UNIT_W'(511) : hsv_pkg::UNIT_W'(ONE_I);

    // stage 1
    logic                              v1_reg;
    logic [hsv_pkg::WRAP_W-1:0]        h1_reg,  h1_next;
    logic [hsv_pkg::UNIT_W-1:0]        sat1_reg, sat1_next;
    logic [hsv_pkg::UNIT_W-1:0]        val1_reg, val1_next;
    logic [hsv_pkg::UNIT_W-1:0]        alp1_reg, alp1_next;
    logic                              gray1_reg, gray1_next;
    // stage 2
    logic                              v2_reg;
    hsv_pkg::hsv_sect_t                s2_reg, s2_next;

    logic rdy1, rdy2;
    logic signed [hsv_pkg::HUE_W:0] h_wide;
    logic [hsv_pkg::WRAP_W-1:0]     base;

    function automatic logic [hsv_pkg::UNIT_W-1:0] clamp_unit(
        input logic signed [hsv_pkg::UNIT_W-1:0] x
    );
        logic [CMP_W-1:0] mag;
        mag = CMP_W'(x[hsv_pkg::UNIT_W-2:0]);
        if (x[hsv_pkg::UNIT_W-1])
            return '0;
        else if (mag > CMP_W'(ONE_I))
            return ONE_CLAMP;
        else
            return x;
    endfunction

    assign rdy2      = !v2_reg || out_ready;
    assign rdy1      = !v1_reg || rdy2;
    assign in_ready  = rdy1;
    assign out_valid = v2_reg;
    assign out_data  = s2_reg;

    // hue wrap into 0..23039
    always_comb
    begin
        h_wide = (hsv_pkg::HUE_W+1)'(hue_angle);
        if (hue_angle < -(hsv_pkg::HUE_W+1)'(hsv_pkg::HUE_TURN))
            h_wide = h_wide + (hsv_pkg::HUE_W+1)'(2 * hsv_pkg::HUE_TURN);
        else if (hue_angle < 0)
            h_wide = h_wide + (hsv_pkg::HUE_W+1)'(hsv_pkg::HUE_TURN);
        else if (h_wide >= (hsv_pkg::HUE_W+1)'(hsv_pkg::HUE_TURN))
            h_wide = h_wide - (hsv_pkg::HUE_W+1)'(hsv_pkg::HUE_TURN);
        h1_next = h_wide[hsv_pkg::WRAP_W-1:0];

        gray1_next = (saturation <= 0);
        sat1_next  = clamp_unit(saturation);
        val1_next  = clamp_unit(brightness);
        alp1_next  = clamp_unit(alpha_in);
    end

    // sector search over five boundaries
    always_comb
    begin
        s2_next = s2_reg;
        if (h1_reg >= hsv_pkg::WRAP_W'(5 * hsv_pkg::HUE_SECTOR))
        begin
            s2_next.sector = hsv_pkg::SEC_MAG_RED;
            base           = hsv_pkg::WRAP_W'(5 * hsv_pkg::HUE_SECTOR);
        end
        else if (h1_reg >= hsv_pkg::WRAP_W'(4 * hsv_pkg::HUE_SECTOR))
        begin
            s2_next.sector = hsv_pkg::SEC_BLU_MAG;
            base           = hsv_pkg::WRAP_W'(4 * hsv_pkg::HUE_SECTOR);
        end
        else if (h1_reg >= hsv_pkg::WRAP_W'(3 * hsv_pkg::HUE_SECTOR))
        begin
            s2_next.sector = hsv_pkg::SEC_CYN_BLU;
            base           = hsv_pkg::WRAP_W'(3 * hsv_pkg::HUE_SECTOR);
        end
        else if (h1_reg >= hsv_pkg::WRAP_W'(2 * hsv_pkg::HUE_SECTOR))
        begin
            s2_next.sector = hsv_pkg::SEC_GRN_CYN;
            base           = hsv_pkg::WRAP_W'(2 * hsv_pkg::HUE_SECTOR);
        end
        else if (h1_reg >= hsv_pkg::WRAP_W'(hsv_pkg::HUE_SECTOR))
        begin
            s2_next.sector = hsv_pkg::SEC_YEL_GRN;
            base           = hsv_pkg::WRAP_W'(hsv_pkg::HUE_SECTOR);
        end
        else
        begin
            s2_next.sector = hsv_pkg::SEC_RED_YEL;
            base           = '0;
        end
        s2_next.rem  = hsv_pkg::REM_W'(h1_reg - base);
        s2_next.sat  = sat1_reg;
        s2_next.val  = val1_reg;
        s2_next.alp  = alp1_reg;
        s2_next.gray = gray1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            h1_reg    <= h1_next;
            sat1_reg  <= sat1_next;
            val1_reg  <= val1_next;
            alp1_reg  <= alp1_next;
            gray1_reg <= gray1_next;
        end
        if (rdy2 && v1_reg)
            s2_reg <= s2_next;
    end

    a_hue_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> (h1_reg < hsv_pkg::WRAP_W'(hsv_pkg::HUE_TURN)))
        else $error("wrapped hue out of range");

endmodule

`default_nettype wire

// ===== rtl/hsv_mix.sv =====
// forms the p/q/t mix factors and picks them per sector, two register stages
// depends on hsv_pkg
`default_nettype none

module hsv_mix #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire hsv_pkg::hsv_sect_t               in_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [FRAC_BITS+11:0]                 x_r,
    output logic [FRAC_BITS+11:0]                 x_g,
    output logic [FRAC_BITS+11:0]                 x_b,
    output logic [hsv_pkg::UNIT_W-1:0]            val,
    output logic [hsv_pkg::UNIT_W-1:0]            alp
);

    localparam int XW    = FRAC_BITS + 12;
    localparam int PW    = FRAC_BITS + 13;
    localparam int ONE_I = 1 << FRAC_BITS;
    localparam int PRD_W = hsv_pkg::UNIT_W + hsv_pkg::REM_W;
    localparam logic [XW-1:0] FULL = XW'(ONE_I * hsv_pkg::HUE_SECTOR);

    // stage 3
    logic                          v3_reg;
    logic [PRD_W-1:0]              prodq_reg, prodq_next;
    logic [PRD_W-1:0]              prodt_reg, prodt_next;
    logic [XW-1:0]                 pnx_reg,   pnx_next;
    hsv_pkg::sector_t              sec3_reg;
    logic                          gray3_reg;
    logic [hsv_pkg::UNIT_W-1:0]    val3_reg, alp3_reg;
    // stage 4
    logic                          v4_reg;
    logic [XW-1:0]                 xr_reg, xr_next;
    logic [XW-1:0]                 xg_reg, xg_next;
    logic [XW-1:0]                 xb_reg, xb_next;
    logic [hsv_pkg::UNIT_W-1:0]    val4_reg, alp4_reg;

    logic                          rdy3, rdy4;
    logic [FRAC_BITS:0]            one_minus;
    logic [hsv_pkg::REM_W-1:0]     rem_comp;
    logic [PW-1:0]                 pn_wide;
    logic [XW-1:0]                 qx, tx;

    assign rdy4      = !v4_reg || out_ready;
    assign rdy3      = !v3_reg || rdy4;
    assign in_ready  = rdy3;
    assign out_valid = v4_reg;
    assign x_r       = xr_reg;
    assign x_g       = xg_reg;
    assign x_b       = xb_reg;
    assign val       = val4_reg;
    assign alp       = alp4_reg;

    // s*f and s*(1-f) scaled by the sector width, and (1-s) times the sector width
    always_comb
    begin
        one_minus  = (FRAC_BITS+1)'(ONE_I) - (FRAC_BITS+1)'(in_data.sat);
        rem_comp   = hsv_pkg::REM_W'(hsv_pkg::HUE_SECTOR) - in_data.rem;
        prodq_next = PRD_W'(in_data.sat) * PRD_W'(in_data.rem);
        prodt_next = PRD_W'(in_data.sat) * PRD_W'(rem_comp);
        pn_wide    = (PW'(one_minus) << 12) - (PW'(one_minus) << 8);
        pnx_next   = pn_wide[XW-1:0];
    end

    always_comb
    begin
        qx = FULL - XW'(prodq_reg);
        tx = FULL - XW'(prodt_reg);
        if (gray3_reg)
        begin
            xr_next = FULL;
            xg_next = FULL;
            xb_next = FULL;
        end
        else
        begin
            case (sec3_reg)
                hsv_pkg::SEC_RED_YEL:
                begin
                    xr_next = FULL; xg_next = tx;   xb_next = pnx_reg;
                end
                hsv_pkg::SEC_YEL_GRN:
                begin
                    xr_next = qx;   xg_next = FULL; xb_next = pnx_reg;
                end
                hsv_pkg::SEC_GRN_CYN:
                begin
                    xr_next = pnx_reg; xg_next = FULL; xb_next = tx;
                end
                hsv_pkg::SEC_CYN_BLU:
                begin
                    xr_next = pnx_reg; xg_next = qx; xb_next = FULL;
                end
                hsv_pkg::SEC_BLU_MAG:
                begin
                    xr_next = tx;   xg_next = pnx_reg; xb_next = FULL;
                end
                hsv_pkg::SEC_MAG_RED:
                begin
                    xr_next = FULL; xg_next = pnx_reg; xb_next = qx;
                end
                default:
                begin
                    xr_next = FULL; xg_next = FULL; xb_next = FULL;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy3)
                v3_reg <= in_valid;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && in_valid)
        begin
            prodq_reg <= prodq_next;
            prodt_reg <= prodt_next;
            pnx_reg   <= pnx_next;
            sec3_reg  <= in_data.sector;
            gray3_reg <= in_data.gray;
            val3_reg  <= in_data.val;
            alp3_reg  <= in_data.alp;
        end
        if (rdy4 && v3_reg)
        begin
            xr_reg   <= xr_next;
            xg_reg   <= xg_next;
            xb_reg   <= xb_next;
            val4_reg <= val3_reg;
            alp4_reg <= alp3_reg;
        end
    end

    a_rem_in_sector: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> (in_data.rem < hsv_pkg::REM_W'(hsv_pkg::HUE_SECTOR)))
        else $error("sector remainder out of range");

    a_gray_equal: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && rdy4 && gray3_reg) |=> (xr_reg == FULL && xg_reg == FULL && xb_reg == FULL))
        else $error("gray item did not give equal channels");

endmodule

`default_nettype wire

// ===== rtl/hsv_scale.sv =====
// four channel lanes: multiply by value or alpha, then round(x*255) and saturate
// two register stages, the last one is the output register; depends on hsv_pkg
`default_nettype none

module hsv_scale #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [FRAC_BITS+11:0]         x_r,
    input  wire logic [FRAC_BITS+11:0]         x_g,
    input  wire logic [FRAC_BITS+11:0]         x_b,
    input  wire logic [hsv_pkg::UNIT_W-1:0]    val,
    input  wire logic [hsv_pkg::UNIT_W-1:0]    alp,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [hsv_pkg::OUT_W-1:0]          red,
    output logic [hsv_pkg::OUT_W-1:0]          green,
    output logic [hsv_pkg::OUT_W-1:0]          blue,
    output logic [hsv_pkg::OUT_W-1:0]          alpha_out
);

    localparam int XW    = FRAC_BITS + 12;
    localparam int MW    = XW + hsv_pkg::UNIT_W;
    localparam int SW    = MW + 5;
    localparam int SHIFT = 2 * FRAC_BITS + 8;
    localparam int ONE_I = 1 << FRAC_BITS;
    localparam int LANES = 4;
    localparam logic [XW-1:0] FULL = XW'(ONE_I * hsv_pkg::HUE_SECTOR);
    localparam logic [SW-1:0] RND  = SW'(1) << (SHIFT - 1);

    logic                          v5_reg, v6_reg;
    logic                          rdy5, rdy6;
    logic [MW-1:0]                 m_reg  [LANES];
    logic [MW-1:0]                 m_next [LANES];
    logic [hsv_pkg::OUT_W-1:0]     ch_reg  [LANES];
    logic [hsv_pkg::OUT_W-1:0]     ch_next [LANES];
    logic [XW-1:0]                 lane_x [LANES];
    logic [hsv_pkg::UNIT_W-1:0]    lane_v [LANES];
    logic [SW-1:0]                 sum    [LANES];
    logic [SW-1:0]                 shifted[LANES];
    logic [LANES-1:0]              ovf;

    assign rdy6      = !v6_reg || out_ready;
    assign rdy5      = !v5_reg || rdy6;
    assign in_ready  = rdy5;
    assign out_valid = v6_reg;
    assign red       = ch_reg[0];
    assign green     = ch_reg[1];
    assign blue      = ch_reg[2];
    assign alpha_out = ch_reg[3];

    always_comb
    begin
        lane_x[0] = x_r;  lane_v[0] = val;
        lane_x[1] = x_g;  lane_v[1] = val;
        lane_x[2] = x_b;  lane_v[2] = val;
        lane_x[3] = FULL; lane_v[3] = alp;
        for (int i = 0; i < LANES; i++)
            m_next[i] = MW'(lane_v[i]) * MW'(lane_x[i]);
    end

    // 255/(one*one*3840) reduces to 17/2^(2*frac+8), halves round up
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            sum[i]     = (SW'(m_reg[i]) << 4) + SW'(m_reg[i]) + RND;
            shifted[i] = sum[i] >> SHIFT;
            ovf[i]     = (shifted[i] > SW'(255));
            ch_next[i] = ovf[i] ? '1 : shifted[i][hsv_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (rdy5)
                v5_reg <= in_valid;
            if (rdy6)
                v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (rdy5 && in_valid)
                m_reg[i] <= m_next[i];
            if (rdy6 && v5_reg)
                ch_reg[i] <= ch_next[i];
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        v5_reg |-> (ovf == '0))
        else $error("channel product exceeds full scale");

endmodule

`default_nettype wire

// ===== rtl/hsv_to_rgb_converter.sv =====
// top level of the hsv to rgb converter: front end, mix and scale pipeline
// depends on hsv_pkg, hsv_if, hsv_sector, hsv_mix and hsv_scale
`default_nettype none

// Takes one hsv item per clock and gives one rgb item per clock while the output
// is ready; each item is registered in turn through clamp and hue wrap, sector
// search, mix products, sector select, value multiply, then round and saturate
// into the output register. Each stage holds its item under backpressure and a
// bubble anywhere in the pipeline is filled, so the input stays ready while a
// finished result waits as long as some stage is empty. Hue wraps modulo 360
// degrees in 1/64 degree steps; saturation at or below zero gives gray; all
// channels are round(x*255) with halves rounded up. FRAC_BITS sets the fixed
// point of saturation, value and alpha (2^FRAC_BITS means 1.0).
module hsv_to_rgb_converter #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    hsv_in_if.sink         hsv,
    hsv_out_if.source      rgb
);

    localparam int XW = FRAC_BITS + 12;

    logic                          sect_valid, sect_ready;
    hsv_pkg::hsv_sect_t            sect_data;
    logic                          mix_valid, mix_ready;
    logic [XW-1:0]                 x_r, x_g, x_b;
    logic [hsv_pkg::UNIT_W-1:0]    mix_val, mix_alp;

    hsv_sector #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sector (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (hsv.valid),
        .in_ready   (hsv.ready),
        .hue_angle  (hsv.hue_angle),
        .saturation (hsv.saturation),
        .brightness (hsv.brightness),
        .alpha_in   (hsv.alpha_in),
        .out_valid  (sect_valid),
        .out_ready  (sect_ready),
        .out_data   (sect_data)
    );

    hsv_mix #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sect_valid),
        .in_ready  (sect_ready),
        .in_data   (sect_data),
        .out_valid (mix_valid),
        .out_ready (mix_ready),
        .x_r       (x_r),
        .x_g       (x_g),
        .x_b       (x_b),
        .val       (mix_val),
        .alp       (mix_alp)
    );

    hsv_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mix_valid),
        .in_ready  (mix_ready),
        .x_r       (x_r),
        .x_g       (x_g),
        .x_b       (x_b),
        .val       (mix_val),
        .alp       (mix_alp),
        .out_valid (rgb.valid),
        .out_ready (rgb.ready),
        .red       (rgb.red),
        .green     (rgb.green),
        .blue      (rgb.blue),
        .alpha_out (rgb.alpha_out)
    );

endmodule

`default_nettype wire
